@@ sv/edd_pkg.sv @@
`timescale 1ns / 1ps

package edd_pkg;

    // request kinds
    localparam logic [1:0] KIND_SRC = 2'd0;
    localparam logic [1:0] KIND_TGT = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_DONE
    } t_state;

    // control that travels with each wavefront token
    typedef struct packed {
        logic valid;
        logic last;
    } t_wave_ctl;

endpackage

@@ sv/edd_ram.sv @@
`timescale 1ns / 1ps

module edd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/edd_cell.sv @@
`timescale 1ns / 1ps

// One DP column: holds target char and D[i-1][j], produces D[i][j].
module edd_cell #(
    parameter int IDX = 1,
    parameter int VW  = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_init,
    input  logic                 i_we,
    input  logic [7:0]           i_wsym,
    input  edd_pkg::t_wave_ctl   i_ctl,
    input  logic [7:0]           i_sym,
    input  logic [VW-1:0]        i_left,
    input  logic [VW-1:0]        i_diag,
    output edd_pkg::t_wave_ctl   o_ctl,
    output logic [7:0]           o_sym,
    output logic [VW-1:0]        o_left,
    output logic [VW-1:0]        o_diag
);

    import edd_pkg::*;

    t_wave_ctl     r_ctl;
    logic [7:0]    r_tchar;
    logic [7:0]    r_sym;
    logic [VW-1:0] r_val;
    logic [VW-1:0] r_diag;
    logic [VW-1:0] n_val;
    logic [VW-1:0] w_min;

    always_comb begin
        w_min = i_diag;
        if (r_val < w_min) begin
            w_min = r_val;
        end
        if (i_left < w_min) begin
            w_min = i_left;
        end
        n_val = (i_sym == r_tchar) ? i_diag : w_min + VW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_init) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_tchar <= i_wsym;
        end
        if (i_init) begin
            r_val <= VW'(IDX);
        end else if (i_ctl.valid) begin
            r_val  <= n_val;
            r_diag <= r_val;
            r_sym  <= i_sym;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_sym  = r_sym;
    assign o_left = r_val;
    assign o_diag = r_diag;

endmodule

@@ sv/edit_distance_engine.sv @@
`timescale 1ns / 1ps
// Operation: an append request writes one char to its store; a compute request with m source and n target
//   chars reads the m source chars into the systolic row and waits for the wavefront to pass n cells.
// Throughput: one append per cycle while idle; compute blocks new requests until its result is
//   registered, which waits while a previous result is held and not taken.
// Reset: synchronous active-low; clears lengths, overflow flag, FSM and output valid.
module edit_distance_engine #(
    parameter int MAX_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_symbol,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_distance,
    output logic       o_truncated
);

    import edd_pkg::*;

    // LW holds a length 0..MAX_LEN; AW indexes a store entry
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state        r_state, n_state;

    logic [LW-1:0] r_slen;          // source chars stored
    logic [LW-1:0] r_tlen;          // target chars stored
    logic          r_ovf;           // a char was dropped since last compute
    logic [LW-1:0] r_m, r_n;        // snapshot of lengths for the running compute
    logic          r_trunc;
    logic [LW-1:0] r_rd_idx;        // next source char to read
    logic          r_rd_pend;       // RAM read data is valid this cycle
    logic [LW-1:0] r_feed_row;      // row index i of the token being fed
    logic          r_feed_last;
    logic [LW-1:0] r_dist;
    logic          r_out_valid;
    logic [5:0]    r_out_dist;
    logic          r_out_trunc;

    logic          w_in_acc;
    logic          w_src_wr;
    logic          w_tgt_wr;
    logic          w_run;
    logic          w_empty;
    logic          w_rd_en;
    logic          w_done;
    logic          w_load_out;
    logic [7:0]    w_rdata;

    t_wave_ctl     w_feed_ctl;
    logic [LW-1:0] w_feed_diag;

    // wavefront buses: index 0 is the feed, index k+1 leaves cell k
    t_wave_ctl     w_ctl  [MAX_LEN+1];
    logic [7:0]    w_sym  [MAX_LEN+1];
    logic [LW-1:0] w_left [MAX_LEN+1];
    logic [LW-1:0] w_diag [MAX_LEN+1];
    logic          w_twe  [MAX_LEN];

    //------------------------------------------------------------------
    // request decode
    //------------------------------------------------------------------
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_src_wr = w_in_acc && (i_kind == KIND_SRC) && (r_slen != LW'(MAX_LEN));
    assign w_tgt_wr = w_in_acc && (i_kind == KIND_TGT) && (r_tlen != LW'(MAX_LEN));
    assign w_run    = w_in_acc && (i_kind == KIND_RUN);
    assign w_empty  = (r_slen == '0) || (r_tlen == '0);

    //------------------------------------------------------------------
    // next state
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_run) begin
                    n_state = w_empty ? S_DONE : S_FEED;
                end
            end
            S_FEED: begin
                if (r_rd_idx + LW'(1) == r_m) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // state outputs
    //------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_FEED: w_rd_en = 1'b1;
            S_WAIT: ;
            S_DONE: w_load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    //------------------------------------------------------------------
    // control registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slen      <= '0;
            r_tlen      <= '0;
            r_ovf       <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= w_rd_en;
            if (w_run) begin
                r_slen <= '0;
                r_tlen <= '0;
                r_ovf  <= 1'b0;
            end else begin
                if (w_src_wr) begin
                    r_slen <= r_slen + LW'(1);
                end
                if (w_tgt_wr) begin
                    r_tlen <= r_tlen + LW'(1);
                end
                // append to a full store drops the char
                if (w_in_acc && (i_kind == KIND_SRC || i_kind == KIND_TGT) &&
                    !w_src_wr && !w_tgt_wr) begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // datapath registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            r_m      <= r_slen;
            r_n      <= r_tlen;
            r_trunc  <= r_ovf;
            r_rd_idx <= '0;
            // one string empty: distance is the other length
            r_dist   <= r_slen + r_tlen;
        end
        if (w_rd_en) begin
            r_rd_idx    <= r_rd_idx + LW'(1);
            r_feed_row  <= r_rd_idx + LW'(1);
            r_feed_last <= (r_rd_idx + LW'(1) == r_m);
        end
        if (r_state == S_WAIT && w_done) begin
            r_dist <= w_left[r_n];
        end
        if (w_load_out) begin
            r_out_dist  <= 6'(r_dist);
            r_out_trunc <= r_trunc;
        end
    end

    //------------------------------------------------------------------
    // source store
    //------------------------------------------------------------------
    edd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_src_wr),
        .i_waddr (r_slen[AW-1:0]),
        .i_wdata (i_symbol),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    //------------------------------------------------------------------
    // feed: column 0 of row i is i, diagonal is i-1
    //------------------------------------------------------------------
    assign w_feed_ctl.valid = r_rd_pend;
    assign w_feed_ctl.last  = r_feed_last;
    assign w_feed_diag      = r_feed_row - LW'(1);

    assign w_ctl[0]  = w_feed_ctl;
    assign w_sym[0]  = w_rdata;
    assign w_left[0] = r_feed_row;
    assign w_diag[0] = w_feed_diag;

    //------------------------------------------------------------------
    // systolic row: cell k holds column k+1 and target char k
    //------------------------------------------------------------------
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        assign w_twe[k] = w_tgt_wr && (r_tlen == LW'(k));

        edd_cell #(
            .IDX (k + 1),
            .VW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  (w_run),
            .i_we    (w_twe[k]),
            .i_wsym  (i_symbol),
            .i_ctl   (w_ctl[k]),
            .i_sym   (w_sym[k]),
            .i_left  (w_left[k]),
            .i_diag  (w_diag[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_sym   (w_sym[k+1]),
            .o_left  (w_left[k+1]),
            .o_diag  (w_diag[k+1])
        );
    end

    // the last source row has passed column n once its token leaves cell n-1
    assign w_done = w_ctl[r_n].valid && w_ctl[r_n].last;

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_truncated = r_out_trunc;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slen <= LW'(MAX_LEN)) && (r_tlen <= LW'(MAX_LEN)))
        else $error("store length beyond depth");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_WAIT))
        else $error("wavefront finished outside wait state");

    a_feed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEED) |-> (r_rd_idx < r_m))
        else $error("source read beyond length");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && w_done) |=> (r_state == S_DONE))
        else $error("result not taken after wavefront");
`endif

endmodule
